// ----- rtl/mspq_pkg.sv -----
// ----------------------------------------------------------------------------
// mspq_pkg: shared types and constants for the sorted priority queue
// Slot and command records that pass along the cell chain, status codes and
// the level mapping of a priority.
// ----------------------------------------------------------------------------
`default_nettype none

package mspq_pkg;

    localparam int PRIO_W = 7;
    localparam int PROC_W = 8;
    localparam int LVL_W  = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = -7'sd18;
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 7'sd40;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_SELECTED = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [PROC_W-1:0] proc_id;
    } slot_t;

    typedef struct packed {
        logic              ins;
        logic              sel;
        logic [PRIO_W-1:0] prio;
        logic [PROC_W-1:0] proc_id;
    } cmd_t;

    function automatic logic prio_in_range(logic signed [PRIO_W-1:0] p);
        return (p >= PRIO_MIN) && (p <= PRIO_MAX);
    endfunction

    // up to 10 (negatives included) is level 0, then one level per decade, capped at level 3
    function automatic logic [LVL_W-1:0] level_of(logic signed [PRIO_W-1:0] p);
        logic [LVL_W-1:0] lvl;
        if (p <= 7'sd10)
        begin
            lvl = 2'd0;
        end
        else if (p <= 7'sd20)
        begin
            lvl = 2'd1;
        end
        else if (p <= 7'sd30)
        begin
            lvl = 2'd2;
        end
        else
        begin
            lvl = 2'd3;
        end
        return lvl;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/multilevel_sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// multilevel_sorted_priority_queue_core: four-level sorted process queue
// A chain of CAPACITY slot cells kept in ascending priority order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry operation, priority_in and process_in. An insert puts
//   the entry after all entries of equal or lower priority; a select pops
//   the head. Every input beat yields exactly one output beat with status,
//   process_out, priority_out and level_out.
//   out_valid rises in the cycle after the input beat is accepted. One beat
//   is taken per cycle while in_stall is low: every cell compares against
//   the new priority in parallel and shifts in the same cycle, so the cell
//   chain sets the rate. The result sits in an output register; a new input
//   beat is accepted whenever that register is empty or being drained.
//   While out_stall holds a waiting result, in_stall is raised and the
//   result does not change.
//   Reset empties the queue at once (all slot valid bits cleared) and drops
//   any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_sorted_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               operation,
    input  wire logic signed [mspq_pkg::PRIO_W-1:0] priority_in,
    input  wire logic [mspq_pkg::PROC_W-1:0]        process_in,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [2:0]                              status,
    output logic [mspq_pkg::PROC_W-1:0]             process_out,
    output logic signed [mspq_pkg::PRIO_W-1:0]      priority_out,
    output logic [mspq_pkg::LVL_W-1:0]              level_out
);

    mspq_pkg::slot_t   slots [CAPACITY];
    logic              greater [CAPACITY];
    mspq_pkg::cmd_t    cmd;

    logic              accept;
    logic              in_range;
    logic              full;
    logic              empty;
    logic [mspq_pkg::LVL_W-1:0] in_level;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    mspq_pkg::status_t           status_reg;
    mspq_pkg::status_t           status_next;
    logic [mspq_pkg::PROC_W-1:0] process_reg;
    logic [mspq_pkg::PROC_W-1:0] process_next;
    logic [mspq_pkg::PRIO_W-1:0] priority_reg;
    logic [mspq_pkg::PRIO_W-1:0] priority_next;
    logic [mspq_pkg::LVL_W-1:0]  level_reg;
    logic [mspq_pkg::LVL_W-1:0]  level_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign in_range = mspq_pkg::prio_in_range(priority_in);
    assign in_level = mspq_pkg::level_of(priority_in);
    assign full     = slots[CAPACITY-1].valid;
    assign empty    = !slots[0].valid;

    assign cmd.ins     = accept && (operation == mspq_pkg::OP_INSERT) && in_range && !full;
    assign cmd.sel     = accept && (operation == mspq_pkg::OP_SELECT) && !empty;
    assign cmd.prio    = priority_in;
    assign cmd.proc_id = process_in;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        mspq_pkg::slot_t prev_slot;
        mspq_pkg::slot_t next_slot;
        logic            prev_greater;

        if (i == 0)
        begin : g_head
            assign prev_slot    = '0;
            assign prev_greater = 1'b0;
        end
        else
        begin : g_body
            assign prev_slot    = slots[i-1];
            assign prev_greater = greater[i-1];
        end

        if (i == CAPACITY-1)
        begin : g_tail
            assign next_slot = '0;
        end
        else
        begin : g_link
            assign next_slot = slots[i+1];
        end

        mspq_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .prev_slot    (prev_slot),
            .prev_greater (prev_greater),
            .next_slot    (next_slot),
            .slot         (slots[i]),
            .greater      (greater[i])
        );
    end

    // result of the beat being accepted
    always_comb
    begin
        status_next   = mspq_pkg::ST_INSERTED;
        process_next  = '0;
        priority_next = '0;
        level_next    = '0;
        if (operation == mspq_pkg::OP_INSERT)
        begin
            if (!in_range)
            begin
                status_next = mspq_pkg::ST_DROPPED;
            end
            else if (full)
            begin
                status_next = mspq_pkg::ST_FULL;
            end
            else
            begin
                status_next = mspq_pkg::ST_INSERTED;
                level_next  = in_level;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = mspq_pkg::ST_EMPTY;
            end
            else
            begin
                status_next   = mspq_pkg::ST_SELECTED;
                process_next  = slots[0].proc_id;
                priority_next = slots[0].prio;
                level_next    = mspq_pkg::level_of(slots[0].prio);
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            process_reg  <= process_next;
            priority_reg <= priority_next;
            level_reg    <= level_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign process_out  = process_reg;
    assign priority_out = priority_reg;
    assign level_out    = level_reg;

    a_select_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == mspq_pkg::OP_SELECT && !empty)
        |=> (status_reg == mspq_pkg::ST_SELECTED
             && process_reg == $past(slots[0].proc_id)
             && priority_reg == $past(slots[0].prio)))
        else $error("select did not return the head slot");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == mspq_pkg::OP_INSERT && in_range && full)
        |=> (status_reg == mspq_pkg::ST_FULL && slots[CAPACITY-1].valid))
        else $error("insert into full queue not refused");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins && empty) |=> (slots[0].valid && !$past(slots[0].valid)))
        else $error("insert into empty queue lost");

    a_no_dual_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins && cmd.sel))
        else $error("insert and select in one cycle");

endmodule

`default_nettype wire

// ----- rtl/mspq_cell.sv -----
// ----------------------------------------------------------------------------
// mspq_cell: one slot of the sorted shift-register queue
// Holds one entry. On insert it keeps, takes the new entry, or takes its
// lower neighbour's entry; on select it takes its upper neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mspq_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mspq_pkg::cmd_t  cmd,
    input  wire mspq_pkg::slot_t prev_slot,
    input  wire logic            prev_greater,
    input  wire mspq_pkg::slot_t next_slot,
    output mspq_pkg::slot_t      slot,
    output logic                 greater
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [mspq_pkg::PRIO_W-1:0] prio_reg;
    logic [mspq_pkg::PRIO_W-1:0] prio_next;
    logic [mspq_pkg::PROC_W-1:0] proc_reg;
    logic [mspq_pkg::PROC_W-1:0] proc_next;

    assign slot.valid   = valid_reg;
    assign slot.prio    = prio_reg;
    assign slot.proc_id = proc_reg;

    // empty slots count as greater, so a new entry lands after equal priorities
    assign greater = !valid_reg || ($signed(prio_reg) > $signed(cmd.prio));

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        proc_next  = proc_reg;
        if (cmd.ins)
        begin
            if (prev_greater)
            begin
                valid_next = prev_slot.valid;
                prio_next  = prev_slot.prio;
                proc_next  = prev_slot.proc_id;
            end
            else if (greater)
            begin
                valid_next = 1'b1;
                prio_next  = cmd.prio;
                proc_next  = cmd.proc_id;
            end
        end
        else if (cmd.sel)
        begin
            valid_next = next_slot.valid;
            prio_next  = next_slot.prio;
            proc_next  = next_slot.proc_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        proc_reg <= proc_next;
    end

    // occupied slots form a prefix and stay in ascending order
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        next_slot.valid |-> valid_reg)
        else $error("occupied slot above an empty one");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && next_slot.valid) |-> ($signed(prio_reg) <= $signed(next_slot.prio)))
        else $error("slot order broken");

endmodule

`default_nettype wire
